// ===== design/jepm_pkg.sv =====
// jepm_pkg: shared types, constants and helpers for the jump event peak monitor
// used by every module of the block but jepm_fifo; depends on nothing
`default_nettype none

package jepm_pkg;

  // fixed lane layout of the torque fields
  localparam int LANE_COUNT      = 6;
  localparam int LANES_PER_WORD  = 3;
  localparam int TORQUE_W        = 16;

  // defaults for top level parameters
  localparam int MOTOR_COUNT_DEF = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  // request function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // configuration register reset
  localparam logic [23:0] POST_WINDOW_RST = 24'd500000;

  // "none" markers for the running maxima
  localparam logic signed [24:0] RISE_NONE = 25'sh1000000;
  localparam logic signed [23:0] H24_NONE  = 24'sh800000;

  typedef logic [LANE_COUNT-1:0][TORQUE_W-1:0] lanes_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                query;
    logic [31:0]         time_us;
    logic signed [23:0]  base_height;
    logic signed [23:0]  clearance;
    logic                jump;
    logic                air;
    logic                jump_rise;
    logic                jump_fall;
    logic                air_rise;
    logic [31:0]         win_end_cand;
    lanes_t              cmd;
    lanes_t              app;
    logic [2:0]          motor_select;
  } item_t;

  // one result
  typedef struct packed {
    logic signed [24:0]  height_gain;
    logic                rise_valid;
    logic                in_window;
    logic [15:0]         jump_total;
    logic signed [24:0]  max_rise;
    logic signed [23:0]  apex_height;
    logic signed [23:0]  max_clearance;
    logic signed [15:0]  peak_command;
    logic [31:0]         peak_command_time;
    logic signed [15:0]  peak_applied;
    logic [31:0]         peak_applied_time;
  } result_t;

  // absolute value of a Q8.8 torque, -32768 maps to 32768
  function automatic logic [16:0] mag17(input logic [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? 17'(-ext) : ext;
  endfunction

endpackage

`default_nettype wire

// ===== design/jepm_fifo.sv =====
// jepm_fifo: small register queue with push/full and pop/empty
// generic, no package dependency; DEPTH must be a power of two, at least 2
`default_nettype none

module jepm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  // status
  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/jepm_front.sv =====
// jepm_front: accepts requests, splits torque lanes, detects flag edges
// and precomputes the window end; holds the post window register; uses jepm_pkg
`default_nettype none

module jepm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [23:0]         cfg_data,
  input  wire logic                accept,
  input  wire logic                func,
  input  wire logic [31:0]         time_us,
  input  wire logic signed [23:0]  base_height,
  input  wire logic signed [23:0]  wheel_gap,
  input  wire logic                jump_on,
  input  wire logic                airborne,
  input  wire logic [47:0]         command_torques_low,
  input  wire logic [47:0]         command_torques_high,
  input  wire logic [47:0]         applied_torques_low,
  input  wire logic [47:0]         applied_torques_high,
  input  wire logic [2:0]          motor_select,
  output jepm_pkg::item_t          item
);
  import jepm_pkg::*;

  logic [23:0] post_r;
  logic        prev_jump_r, prev_jump_nxt;
  logic        prev_air_r, prev_air_nxt;
  logic [32:0] win_sum;
  logic        sample;

  assign cfg_ready = 1'b1;
  assign sample    = (func == FUNC_SAMPLE);

  // window end with saturation at 32 bits
  assign win_sum = {1'b0, time_us} + {9'd0, post_r};

  // classification
  always_comb begin
    item.query        = (func == FUNC_QUERY);
    item.time_us      = time_us;
    item.base_height  = base_height;
    item.clearance    = wheel_gap;
    item.jump         = jump_on;
    item.air          = airborne;
    item.jump_rise    = sample && jump_on && !prev_jump_r;
    item.jump_fall    = sample && !jump_on && prev_jump_r;
    item.air_rise     = sample && airborne && !prev_air_r;
    item.win_end_cand = win_sum[32] ? 32'hFFFF_FFFF : win_sum[31:0];
    item.motor_select = motor_select;
    for (int m = 0; m < LANES_PER_WORD; m++) begin
      item.cmd[m]                  = command_torques_low[m*TORQUE_W +: TORQUE_W];
      item.cmd[m + LANES_PER_WORD] = command_torques_high[m*TORQUE_W +: TORQUE_W];
      item.app[m]                  = applied_torques_low[m*TORQUE_W +: TORQUE_W];
      item.app[m + LANES_PER_WORD] = applied_torques_high[m*TORQUE_W +: TORQUE_W];
    end
  end

  // previous flags follow accepted samples only
  always_comb begin
    prev_jump_nxt = prev_jump_r;
    prev_air_nxt  = prev_air_r;
    if (accept && sample) begin
      prev_jump_nxt = jump_on;
      prev_air_nxt  = airborne;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r      <= POST_WINDOW_RST;
      prev_jump_r <= 1'b0;
      prev_air_r  <= 1'b0;
    end else begin
      prev_jump_r <= prev_jump_nxt;
      prev_air_r  <= prev_air_nxt;
      if (cfg_valid && cfg_ready) begin
        post_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/jepm_back.sv =====
// jepm_back: event state, running maxima and per-motor torque peaks;
// executes one classified request per cycle unless the result queue is full; uses jepm_pkg
`default_nettype none

module jepm_back #(
  parameter int MOTOR_COUNT = jepm_pkg::MOTOR_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jepm_pkg::item_t item,
  input  wire logic            item_valid,
  output logic                 item_pop,
  input  wire logic            res_full,
  output logic                 res_push,
  output jepm_pkg::result_t    res
);
  import jepm_pkg::*;

  logic [15:0]        cnt_r, cnt_nxt;
  logic               latched_r, latched_nxt, latched_a;
  logic signed [23:0] takeoff_r, takeoff_nxt;
  logic [31:0]        win_end_r, win_end_nxt;
  logic signed [24:0] best_rise_r, best_rise_nxt;
  logic signed [23:0] best_apex_r, best_apex_nxt;
  logic signed [23:0] best_clr_r, best_clr_nxt;
  logic [15:0]        cpk_val_r [MOTOR_COUNT];
  logic [31:0]        cpk_t_r   [MOTOR_COUNT];
  logic [15:0]        apk_val_r [MOTOR_COUNT];
  logic [31:0]        apk_t_r   [MOTOR_COUNT];
  logic [15:0]        cpk_val_nxt [MOTOR_COUNT];
  logic [31:0]        cpk_t_nxt   [MOTOR_COUNT];
  logic [15:0]        apk_val_nxt [MOTOR_COUNT];
  logic [31:0]        apk_t_nxt   [MOTOR_COUNT];
  logic               adv, do_sample, take, win;
  logic signed [24:0] rise;

  assign adv       = item_valid && !res_full;
  assign item_pop  = adv;
  assign res_push  = adv;
  assign do_sample = adv && !item.query;

  // jump counter, takeoff latch and window end
  always_comb begin
    cnt_nxt     = cnt_r;
    latched_a   = latched_r;
    win_end_nxt = win_end_r;
    if (item.jump_rise) begin
      if (cnt_r != 16'hFFFF) begin
        cnt_nxt = cnt_r + 16'd1;
      end
      latched_a = 1'b0;
    end else if (item.jump_fall) begin
      win_end_nxt = item.win_end_cand;
    end
    take        = (cnt_nxt != '0) && item.air_rise && !latched_a;
    latched_nxt = latched_a || take;
    takeoff_nxt = take ? item.base_height : takeoff_r;
    win         = !item.query && (cnt_nxt != '0)
                  && (item.jump || (item.time_us <= win_end_nxt));
    rise        = latched_nxt
                  ? ($signed({item.base_height[23], item.base_height})
                     - $signed({takeoff_nxt[23], takeoff_nxt}))
                  : '0;
  end

  // running maxima inside the window
  always_comb begin
    best_rise_nxt = best_rise_r;
    best_apex_nxt = best_apex_r;
    best_clr_nxt  = best_clr_r;
    if (win) begin
      if (item.air && latched_nxt && (rise > best_rise_r)) begin
        best_rise_nxt = rise;
        best_apex_nxt = item.base_height;
      end
      if (item.clearance > best_clr_r) begin
        best_clr_nxt = item.clearance;
      end
    end
  end

  // per-motor absolute torque peaks, earliest wins on a tie
  always_comb begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      cpk_val_nxt[m] = cpk_val_r[m];
      cpk_t_nxt[m]   = cpk_t_r[m];
      apk_val_nxt[m] = apk_val_r[m];
      apk_t_nxt[m]   = apk_t_r[m];
      if (win && (mag17(item.cmd[m]) > mag17(cpk_val_r[m]))) begin
        cpk_val_nxt[m] = item.cmd[m];
        cpk_t_nxt[m]   = item.time_us;
      end
      if (win && (mag17(item.app[m]) > mag17(apk_val_r[m]))) begin
        apk_val_nxt[m] = item.app[m];
        apk_t_nxt[m]   = item.time_us;
      end
    end
  end

  // result assembly
  always_comb begin
    res.height_gain       = item.query ? '0 : rise;
    res.rise_valid        = !item.query && latched_nxt;
    res.in_window         = win;
    res.jump_total        = cnt_nxt;
    res.max_rise          = best_rise_nxt;
    res.apex_height       = best_apex_nxt;
    res.max_clearance     = best_clr_nxt;
    res.peak_command      = '0;
    res.peak_command_time = '0;
    res.peak_applied      = '0;
    res.peak_applied_time = '0;
    if (item.query) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        if (item.motor_select == 3'(m)) begin
          res.peak_command      = cpk_val_r[m];
          res.peak_command_time = cpk_t_r[m];
          res.peak_applied      = apk_val_r[m];
          res.peak_applied_time = apk_t_r[m];
        end
      end
    end
  end

  // state registers, updated by samples only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      latched_r   <= 1'b0;
      takeoff_r   <= '0;
      win_end_r   <= '0;
      best_rise_r <= RISE_NONE;
      best_apex_r <= H24_NONE;
      best_clr_r  <= H24_NONE;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        cpk_val_r[m] <= '0;
        cpk_t_r[m]   <= '0;
        apk_val_r[m] <= '0;
        apk_t_r[m]   <= '0;
      end
    end else if (do_sample) begin
      cnt_r       <= cnt_nxt;
      latched_r   <= latched_nxt;
      takeoff_r   <= takeoff_nxt;
      win_end_r   <= win_end_nxt;
      best_rise_r <= best_rise_nxt;
      best_apex_r <= best_apex_nxt;
      best_clr_r  <= best_clr_nxt;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        cpk_val_r[m] <= cpk_val_nxt[m];
        cpk_t_r[m]   <= cpk_t_nxt[m];
        apk_val_r[m] <= apk_val_nxt[m];
        apk_t_r[m]   <= apk_t_nxt[m];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/jump_event_peak_monitor_top.sv =====
// Jump event peak monitor, top level.
// Requests enter on the in_ queue port (push/full): an accepted request with
// in_func low records one telemetry sample, with in_func high it queries the
// running maxima and the peaks of motor in_motor_select.
// Results leave on the out_ queue port (empty/pop), one per request, in order;
// the oldest result is shown while out_empty is low and taken on out_pop.
// The post window register is written on cfg_valid/cfg_ready (ready is always
// high); write it only while no request is in flight.
// An accepted request is held in the request queue; the execute stage reads it
// from there and writes its result into the result queue, which shows it.
// Throughput: one request per cycle while the result queue has room, set by the
// execute stage that updates all motor peak lanes in parallel.
// When the receiver stops popping, the result queue fills, the execute stage
// holds, then the request queue fills and in_full rises; nothing is dropped.
// Synchronous active-low reset empties both queues, clears the counters and
// peaks, sets the maxima to "none" and the post window to 500000 us.
// Depends on jepm_pkg, jepm_front, jepm_fifo and jepm_back.
`default_nettype none

module jump_event_peak_monitor_top #(
  parameter int MOTOR_COUNT = jepm_pkg::MOTOR_COUNT_DEF,
  parameter int QUEUE_DEPTH = jepm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [23:0]         cfg_data,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic                in_func,
  input  wire logic [31:0]         in_time_us,
  input  wire logic signed [23:0]  in_base_height,
  input  wire logic signed [23:0]  in_wheel_gap,
  input  wire logic                in_jump_on,
  input  wire logic                in_airborne,
  input  wire logic [47:0]         in_command_torques_low,
  input  wire logic [47:0]         in_command_torques_high,
  input  wire logic [47:0]         in_applied_torques_low,
  input  wire logic [47:0]         in_applied_torques_high,
  input  wire logic [2:0]          in_motor_select,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic signed [24:0]       out_height_gain,
  output logic                     out_rise_valid,
  output logic                     out_in_window,
  output logic [15:0]              out_jump_total,
  output logic signed [24:0]       out_max_rise,
  output logic signed [23:0]       out_apex_height,
  output logic signed [23:0]       out_max_clearance,
  output logic signed [15:0]       out_peak_command,
  output logic [31:0]              out_peak_command_time,
  output logic signed [15:0]       out_peak_applied,
  output logic [31:0]              out_peak_applied_time
);
  import jepm_pkg::*;

  item_t   fr_item, bk_item;
  result_t bk_res, q_res;
  logic    in_accept;
  logic    mid_empty, mid_pop;
  logic    res_full, res_push;

  assign in_accept = in_push && !in_full;

  // front: classify and edge-detect
  jepm_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .accept               (in_accept),
    .func                 (in_func),
    .time_us              (in_time_us),
    .base_height          (in_base_height),
    .wheel_gap            (in_wheel_gap),
    .jump_on              (in_jump_on),
    .airborne             (in_airborne),
    .command_torques_low  (in_command_torques_low),
    .command_torques_high (in_command_torques_high),
    .applied_torques_low  (in_applied_torques_low),
    .applied_torques_high (in_applied_torques_high),
    .motor_select         (in_motor_select),
    .item                 (fr_item)
  );

  // request queue between front and back
  jepm_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (fr_item),
    .full  (in_full),
    .pop   (mid_pop),
    .rdata (bk_item),
    .empty (mid_empty)
  );

  // back: execute against event state
  jepm_back #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (bk_item),
    .item_valid (!mid_empty),
    .item_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (bk_res)
  );

  // result queue
  jepm_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (bk_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (q_res),
    .empty (out_empty)
  );

  // result fields to ports
  assign out_height_gain       = q_res.height_gain;
  assign out_rise_valid        = q_res.rise_valid;
  assign out_in_window         = q_res.in_window;
  assign out_jump_total        = q_res.jump_total;
  assign out_max_rise          = q_res.max_rise;
  assign out_apex_height       = q_res.apex_height;
  assign out_max_clearance     = q_res.max_clearance;
  assign out_peak_command      = q_res.peak_command;
  assign out_peak_command_time = q_res.peak_command_time;
  assign out_peak_applied      = q_res.peak_applied;
  assign out_peak_applied_time = q_res.peak_applied_time;

endmodule

`default_nettype wire

// ===== design/jepm_checker.sv =====
// jepm_checker: port-level assertions for the jump event peak monitor
// bound to jump_event_peak_monitor_top; uses jepm_pkg for the "none" markers
`default_nettype none

module jepm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire logic signed [24:0]  out_height_gain,
  input wire logic                out_rise_valid,
  input wire logic                out_in_window,
  input wire logic [15:0]         out_jump_total,
  input wire logic signed [24:0]  out_max_rise
);
  import jepm_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // a shown result that is not taken stays shown unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_jump_total)
                                  && $stable(out_max_rise)))
    else $error("stalled result changed");

  // rise is zero unless a takeoff is latched
  a_rise_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_rise_valid) |-> (out_height_gain == '0))
    else $error("rise without latched takeoff");

  // window and takeoff need at least one jump
  a_window_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_in_window || out_rise_valid)) |-> (out_jump_total != '0))
    else $error("window or takeoff before first jump");

  // a recorded peak rise needs at least one jump
  a_maxima_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_max_rise != RISE_NONE)) |-> (out_jump_total != '0))
    else $error("peak rise before first jump");

endmodule

bind jump_event_peak_monitor_top jepm_checker u_jepm_checker (.*);

`default_nettype wire

// ===== tb/jepm_peak_checker.sv =====
// jepm_peak_checker: watches the register, request and result ports of the jump
// event peak monitor, predicts every result and compares it field by field
// depends on jepm_pkg for the result layout and the register reset value

module jepm_peak_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [23:0]        cfg_data,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_func,
  input  logic [31:0]        in_time_us,
  input  logic signed [23:0] in_base_height,
  input  logic signed [23:0] in_wheel_gap,
  input  logic               in_jump_on,
  input  logic               in_airborne,
  input  logic [47:0]        in_command_torques_low,
  input  logic [47:0]        in_command_torques_high,
  input  logic [47:0]        in_applied_torques_low,
  input  logic [47:0]        in_applied_torques_high,
  input  logic [2:0]         in_motor_select,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [24:0] out_height_gain,
  input  logic               out_rise_valid,
  input  logic               out_in_window,
  input  logic [15:0]        out_jump_total,
  input  logic signed [24:0] out_max_rise,
  input  logic signed [23:0] out_apex_height,
  input  logic signed [23:0] out_max_clearance,
  input  logic signed [15:0] out_peak_command,
  input  logic [31:0]        out_peak_command_time,
  input  logic signed [15:0] out_peak_applied,
  input  logic [31:0]        out_peak_applied_time,
  output int                 fail_count,
  output int                 outstanding
);

  localparam int   MOTORS     = jepm_pkg::MOTOR_COUNT_DEF;
  localparam logic FUNC_QUERY = jepm_pkg::FUNC_QUERY;

  // predicted monitor state
  logic [23:0]        window_len;
  logic               prev_jump;
  logic               prev_air;
  logic [15:0]        jumps_seen;
  logic               takeoff_held;
  logic signed [23:0] takeoff_h;
  logic [31:0]        window_close;
  logic signed [24:0] top_rise;
  logic signed [23:0] top_apex;
  logic signed [23:0] top_clear;
  logic signed [15:0] cmd_peak [MOTORS];
  logic [31:0]        cmd_stamp [MOTORS];
  logic signed [15:0] app_peak [MOTORS];
  logic [31:0]        app_stamp [MOTORS];

  // results still owed by the block, oldest first
  jepm_pkg::result_t  owed_results [$];
  int                 mismatches;
  int                 stray;
  int                 results_checked;

  // magnitude of a q8.8 torque, the most negative code counts as 32768
  function automatic int torque_mag(logic signed [15:0] v);
    int x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [15:0] lane_of(logic [47:0] lo, logic [47:0] hi, int m);
    return (m < 3) ? lo[16*m +: 16] : hi[16*(m-3) +: 16];
  endfunction

  task automatic clear_monitor();
    window_len   = jepm_pkg::POST_WINDOW_RST;
    prev_jump    = 1'b0;
    prev_air     = 1'b0;
    jumps_seen   = '0;
    takeoff_held = 1'b0;
    takeoff_h    = '0;
    window_close = '0;
    top_rise     = jepm_pkg::RISE_NONE;
    top_apex     = jepm_pkg::H24_NONE;
    top_clear    = jepm_pkg::H24_NONE;
    for (int m = 0; m < MOTORS; m++) begin
      cmd_peak[m]  = '0;
      cmd_stamp[m] = '0;
      app_peak[m]  = '0;
      app_stamp[m] = '0;
    end
  endtask

  // apply one accepted request to the predicted state and build its result
  task automatic monitor_step(output jepm_pkg::result_t r);
    logic signed [24:0] rise;
    logic [32:0]        close_sum;
    logic signed [15:0] c;
    logic signed [15:0] a;
    logic               open;
    r = '0;
    if (in_func != FUNC_QUERY) begin
      rise = '0;
      // jump edges: count starts, set the window end on the falling edge
      if (in_jump_on && !prev_jump) begin
        if (jumps_seen != 16'hffff) jumps_seen = jumps_seen + 16'd1;
        takeoff_held = 1'b0;
      end else if (!in_jump_on && prev_jump) begin
        close_sum    = {1'b0, in_time_us} + {9'd0, window_len};
        window_close = close_sum[32] ? 32'hffff_ffff : close_sum[31:0];
      end
      // first liftoff of this jump latches the takeoff height
      if (jumps_seen != 0 && in_airborne && !prev_air && !takeoff_held) begin
        takeoff_h    = in_base_height;
        takeoff_held = 1'b1;
      end
      open = (jumps_seen != 0) && (in_jump_on || in_time_us <= window_close);
      if (takeoff_held)
        rise = $signed({in_base_height[23], in_base_height})
               - $signed({takeoff_h[23], takeoff_h});
      // running maxima and torque peaks inside the window
      if (open) begin
        if (in_airborne && takeoff_held && rise > top_rise) begin
          top_rise = rise;
          top_apex = in_base_height;
        end
        if (in_wheel_gap > top_clear) top_clear = in_wheel_gap;
        for (int m = 0; m < MOTORS; m++) begin
          c = lane_of(in_command_torques_low, in_command_torques_high, m);
          a = lane_of(in_applied_torques_low, in_applied_torques_high, m);
          if (torque_mag(c) > torque_mag(cmd_peak[m])) begin
            cmd_peak[m]  = c;
            cmd_stamp[m] = in_time_us;
          end
          if (torque_mag(a) > torque_mag(app_peak[m])) begin
            app_peak[m]  = a;
            app_stamp[m] = in_time_us;
          end
        end
      end
      prev_jump     = in_jump_on;
      prev_air      = in_airborne;
      r.height_gain = rise;
      r.rise_valid  = takeoff_held;
      r.in_window   = open;
    end else if (in_motor_select < MOTORS) begin
      r.peak_command      = cmd_peak[in_motor_select];
      r.peak_command_time = cmd_stamp[in_motor_select];
      r.peak_applied      = app_peak[in_motor_select];
      r.peak_applied_time = app_stamp[in_motor_select];
    end
    r.jump_total    = jumps_seen;
    r.max_rise      = top_rise;
    r.apex_height   = top_apex;
    r.max_clearance = top_clear;
  endtask

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches + stray <= 10)
        $display("result %0d field %s: expected %h, got %h", results_checked, name, want_v,
                 got_v);
    end
  endfunction

  // sample at the edge: config writes, taken results, accepted requests
  always @(posedge clk) begin
    jepm_pkg::result_t want;
    if (!rst_n) begin
      clear_monitor();
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) window_len = cfg_data;
      // results first: a request taken at this edge cannot show up yet
      if (out_pop && !out_empty) begin
        if (owed_results.size() == 0) begin
          stray++;
          if (mismatches + stray <= 10)
            $display("result %0d arrived with nothing owed", results_checked);
        end else begin
          want = owed_results.pop_front();
          check_field("height_gain", want.height_gain, out_height_gain);
          check_field("rise_valid", want.rise_valid, out_rise_valid);
          check_field("in_window", want.in_window, out_in_window);
          check_field("jump_total", want.jump_total, out_jump_total);
          check_field("max_rise", want.max_rise, out_max_rise);
          check_field("apex_height", want.apex_height, out_apex_height);
          check_field("max_clearance", want.max_clearance, out_max_clearance);
          check_field("peak_command", want.peak_command, out_peak_command);
          check_field("peak_command_time", want.peak_command_time, out_peak_command_time);
          check_field("peak_applied", want.peak_applied, out_peak_applied);
          check_field("peak_applied_time", want.peak_applied_time, out_peak_applied_time);
        end
        results_checked++;
      end
      if (in_push && !in_full) begin
        monitor_step(want);
        owed_results.push_back(want);
      end
    end
    outstanding <= owed_results.size();
    fail_count  <= mismatches + stray;
  end

endmodule

// ===== tb/tb_jump_event_peak_monitor_top.sv =====
// tb_jump_event_peak_monitor_top: drives requests and register writes into the
// jump event peak monitor and gives the verdict; depends on jepm_pkg, the block
// top level and jepm_peak_checker, which does all prediction and comparison

module tb_jump_event_peak_monitor_top;

  localparam logic FUNC_SAMPLE = jepm_pkg::FUNC_SAMPLE;
  localparam logic FUNC_QUERY  = jepm_pkg::FUNC_QUERY;

  // one request as the sender sees it
  typedef struct {
    logic               func;
    logic [31:0]        stamp;
    logic signed [23:0] height;
    logic signed [23:0] clearance;
    logic               jump;
    logic               air;
    logic [47:0]        cmd_lo;
    logic [47:0]        cmd_hi;
    logic [47:0]        app_lo;
    logic [47:0]        app_hi;
    logic [2:0]         sel;
  } telemetry_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [23:0]        cfg_data = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_func = 1'b0;
  logic [31:0]        in_time_us = '0;
  logic signed [23:0] in_base_height = '0;
  logic signed [23:0] in_wheel_gap = '0;
  logic               in_jump_on = 1'b0;
  logic               in_airborne = 1'b0;
  logic [47:0]        in_command_torques_low = '0;
  logic [47:0]        in_command_torques_high = '0;
  logic [47:0]        in_applied_torques_low = '0;
  logic [47:0]        in_applied_torques_high = '0;
  logic [2:0]         in_motor_select = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [24:0] out_height_gain;
  logic               out_rise_valid;
  logic               out_in_window;
  logic [15:0]        out_jump_total;
  logic signed [24:0] out_max_rise;
  logic signed [23:0] out_apex_height;
  logic signed [23:0] out_max_clearance;
  logic signed [15:0] out_peak_command;
  logic [31:0]        out_peak_command_time;
  logic signed [15:0] out_peak_applied;
  logic [31:0]        out_peak_applied_time;
  int                 fail_count;
  int                 outstanding;

  int                 samples_sent;
  int                 queries_sent;
  int                 settings_used;
  int                 burst_left;
  int                 episodes;
  logic [31:0]        clock_us;

  jump_event_peak_monitor_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_data                (cfg_data),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_func                 (in_func),
    .in_time_us              (in_time_us),
    .in_base_height          (in_base_height),
    .in_wheel_gap            (in_wheel_gap),
    .in_jump_on              (in_jump_on),
    .in_airborne             (in_airborne),
    .in_command_torques_low  (in_command_torques_low),
    .in_command_torques_high (in_command_torques_high),
    .in_applied_torques_low  (in_applied_torques_low),
    .in_applied_torques_high (in_applied_torques_high),
    .in_motor_select         (in_motor_select),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_height_gain         (out_height_gain),
    .out_rise_valid          (out_rise_valid),
    .out_in_window           (out_in_window),
    .out_jump_total          (out_jump_total),
    .out_max_rise            (out_max_rise),
    .out_apex_height         (out_apex_height),
    .out_max_clearance       (out_max_clearance),
    .out_peak_command        (out_peak_command),
    .out_peak_command_time   (out_peak_command_time),
    .out_peak_applied        (out_peak_applied),
    .out_peak_applied_time   (out_peak_applied_time)
  );

  jepm_peak_checker peak_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_data                (cfg_data),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_func                 (in_func),
    .in_time_us              (in_time_us),
    .in_base_height          (in_base_height),
    .in_wheel_gap            (in_wheel_gap),
    .in_jump_on              (in_jump_on),
    .in_airborne             (in_airborne),
    .in_command_torques_low  (in_command_torques_low),
    .in_command_torques_high (in_command_torques_high),
    .in_applied_torques_low  (in_applied_torques_low),
    .in_applied_torques_high (in_applied_torques_high),
    .in_motor_select         (in_motor_select),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_height_gain         (out_height_gain),
    .out_rise_valid          (out_rise_valid),
    .out_in_window           (out_in_window),
    .out_jump_total          (out_jump_total),
    .out_max_rise            (out_max_rise),
    .out_apex_height         (out_apex_height),
    .out_max_clearance       (out_max_clearance),
    .out_peak_command        (out_peak_command),
    .out_peak_command_time   (out_peak_command_time),
    .out_peak_applied        (out_peak_applied),
    .out_peak_applied_time   (out_peak_applied_time),
    .fail_count              (fail_count),
    .outstanding             (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #(64'd8 * 64'd4_000_000);
    $display("jump_event_peak_monitor_top: mismatch");
    $finish;
  end

  // result side: random pop pattern, two long hold-offs to fill the block
  initial begin : result_sink
    int run_len;
    int stall_len;
    int held;
    int popped;
    int holds_done;
    run_len    = 0;
    stall_len  = 0;
    held       = 0;
    popped     = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) popped++;
      if (held > 0) begin
        out_pop <= 1'b0;
        held--;
      end else if (holds_done < 2 && popped >= 300 * (holds_done + 1)) begin
        holds_done++;
        held    = 119;
        out_pop <= 1'b0;
      end else if (run_len > 0) begin
        out_pop <= 1'b1;
        run_len--;
      end else if (stall_len > 0) begin
        out_pop <= 1'b0;
        stall_len--;
      end else begin
        run_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        out_pop   <= 1'b1;
        run_len--;
      end
    end
  end

  function automatic int scaled(int bits);
    int v;
    v = int'($urandom_range(0, (1 << bits) - 1));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // three q8.8 lanes bounded by 2^bits
  function automatic logic [47:0] torque_word(int bits);
    logic [47:0] w;
    for (int m = 0; m < 3; m++) w[16*m +: 16] = 16'(scaled(bits));
    return w;
  endfunction

  function automatic telemetry_t sample_at(logic [31:0] t, logic signed [23:0] h,
                                           logic signed [23:0] c, logic j, logic a);
    telemetry_t r;
    r = '{func: FUNC_SAMPLE, stamp: t, height: h, clearance: c, jump: j, air: a,
          cmd_lo: '0, cmd_hi: '0, app_lo: '0, app_hi: '0, sel: '0};
    return r;
  endfunction

  function automatic telemetry_t query_of(logic [2:0] sel);
    telemetry_t r;
    r      = sample_at('0, '0, '0, 1'b0, 1'b0);
    r.func = FUNC_QUERY;
    r.sel  = sel;
    return r;
  endfunction

  // hold the request until the block takes it
  task automatic push_request(input telemetry_t r);
    in_push                 <= 1'b1;
    in_func                 <= r.func;
    in_time_us              <= r.stamp;
    in_base_height          <= r.height;
    in_wheel_gap            <= r.clearance;
    in_jump_on              <= r.jump;
    in_airborne             <= r.air;
    in_command_torques_low  <= r.cmd_lo;
    in_command_torques_high <= r.cmd_hi;
    in_applied_torques_low  <= r.app_lo;
    in_applied_torques_high <= r.app_hi;
    in_motor_select         <= r.sel;
    do @(posedge clk); while (in_full);
    if (r.func == FUNC_QUERY) queries_sent++;
    else samples_sent++;
  endtask

  // send in bursts with random gaps in between
  task automatic offer(input telemetry_t r);
    int gap;
    push_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    in_push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_window(input logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // one sample at the running clock, sometimes preceded by a query
  task automatic emit(input logic j, input logic a, input int height);
    telemetry_t r;
    int tq_bits;
    int h_bits;
    if ($urandom_range(0, 99) < 15) offer(query_of(3'($urandom_range(0, 7))));
    tq_bits  = (3 + episodes / 6 > 15) ? 15 : 3 + episodes / 6;
    h_bits   = (8 + episodes / 3 > 23) ? 23 : 8 + episodes / 3;
    r        = sample_at(clock_us, 24'(height), 24'(scaled(h_bits)), j, a);
    r.cmd_lo = torque_word(tq_bits);
    r.cmd_hi = torque_word(tq_bits);
    r.app_lo = torque_word(tq_bits);
    r.app_hi = torque_word(tq_bits);
    offer(r);
    clock_us += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 600000) : $urandom_range(0, 3000);
  endtask

  // ground, jump start, flight with bounces, landing, post window
  task automatic jump_episode();
    int ground;
    int h_bits;
    h_bits = (8 + episodes / 3 > 23) ? 23 : 8 + episodes / 3;
    if ($urandom_range(0, 19) == 0) clock_us = 32'hffff_ffff - $urandom_range(0, 20000);
    ground = scaled(h_bits);
    repeat ($urandom_range(0, 3)) emit(1'b0, 1'b0, ground + scaled(4));
    repeat ($urandom_range(1, 3)) emit(1'b1, 1'b0, ground + scaled(4));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 4) == 0) emit(1'b1, 1'b0, ground);
      emit(1'b1, 1'b1, ground + int'($urandom_range(0, 1 << h_bits)));
    end
    repeat ($urandom_range(0, 2)) emit(1'b1, 1'b0, ground + scaled(4));
    repeat ($urandom_range(1, 6)) emit(1'b0, 1'b0, ground + scaled(4));
    episodes++;
  endtask

  // fully random requests
  task automatic noise_burst();
    telemetry_t r;
    repeat ($urandom_range(1, 5)) begin
      r = sample_at($urandom, 24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
      r.func   = 1'($urandom);
      r.sel    = 3'($urandom_range(0, 7));
      r.cmd_lo = {$urandom, $urandom};
      r.cmd_hi = torque_word(15);
      r.app_lo = torque_word(15);
      r.app_hi = {$urandom, $urandom};
      offer(r);
    end
  endtask

  task automatic random_traffic(input int count);
    int start;
    start = samples_sent + queries_sent;
    while (samples_sent + queries_sent - start < count) begin
      if ($urandom_range(0, 9) < 2) noise_burst();
      else jump_episode();
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    telemetry_t  r;
    logic [23:0] windows [4];
    samples_sent  = 0;
    queries_sent  = 0;
    settings_used = 0;
    burst_left    = 0;
    episodes      = 0;
    clock_us      = 32'd1_000_000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any jump: empty peaks, out of range select, no window yet
    offer(query_of(3'd0));
    offer(query_of(3'd7));
    r = sample_at(32'd0, 24'sh800000, 24'sh7fffff, 1'b0, 1'b1);
    r.cmd_lo = {3{16'h8000}};
    offer(r);

    // first jump: extreme torques, then ties that must keep the earlier peak
    r = sample_at(32'd10, 24'sd0, 24'sh800000, 1'b1, 1'b0);
    r.cmd_lo = {16'h0001, 16'h7fff, 16'h8000};
    r.cmd_hi = {16'hffff, 16'h0003, 16'h8001};
    r.app_lo = {16'h0000, 16'h0000, 16'h8000};
    offer(r);
    r = sample_at(32'd20, 24'sd0, 24'sd5, 1'b1, 1'b0);
    r.cmd_lo = {16'h0002, 16'h8001, 16'h8000};
    r.cmd_hi = {16'h0001, 16'hfffd, 16'h7fff};
    r.app_lo = {16'h0000, 16'h0000, 16'h8000};
    offer(r);
    // takeoff at the lowest height, apex at the highest, second liftoff not latched
    offer(sample_at(32'd30, 24'sh800000, 24'sd7, 1'b1, 1'b1));
    offer(sample_at(32'd40, 24'sh7fffff, 24'sd9, 1'b1, 1'b1));
    offer(sample_at(32'd50, 24'sd0, 24'sd0, 1'b1, 1'b0));
    offer(sample_at(32'd60, 24'sd100, 24'sd0, 1'b1, 1'b1));
    // jump ends: window edge is inclusive
    offer(sample_at(32'd70, 24'sd0, 24'sd0, 1'b0, 1'b0));
    offer(sample_at(32'd500070, 24'sd0, 24'sd11, 1'b0, 1'b0));
    offer(sample_at(32'd500071, 24'sd0, 24'sd12, 1'b0, 1'b0));
    for (int m = 0; m < 6; m++) offer(query_of(3'(m)));

    // second jump near the top of time: negative rise, saturated window end
    offer(sample_at(32'hffff_0000, 24'sh7fffff, 24'sd0, 1'b1, 1'b0));
    offer(sample_at(32'hffff_0001, 24'sh7fffff, 24'sd0, 1'b1, 1'b1));
    offer(sample_at(32'hffff_0002, 24'sh800000, 24'sd0, 1'b1, 1'b1));
    offer(sample_at(32'hffff_0003, 24'sd0, 24'sd0, 1'b0, 1'b0));
    offer(sample_at(32'hffff_ffff, 24'sd0, 24'sd13, 1'b0, 1'b0));
    offer(query_of(3'd6));

    // random phases, each under its own post window
    windows[0] = 24'd0;
    windows[1] = 24'hffffff;
    windows[2] = 24'($urandom_range(1, 4000));
    windows[3] = 24'($urandom_range(20000, 300000));
    foreach (windows[i]) begin
      wait_all_results();
      write_window(windows[i]);
      random_traffic(170);
    end

    // back to the reset window for a last couple of jumps
    wait_all_results();
    write_window(jepm_pkg::POST_WINDOW_RST);
    offer(query_of(3'd0));
    jump_episode();
    jump_episode();

    wait_all_results();
    repeat (4) @(posedge clk);
    $display("run covered %0d samples and %0d queries under %0d post window writes,",
             samples_sent, queries_sent, settings_used);
    $display("with %0d random jump episodes plus directed edge and tie cases",
             episodes);
    if (fail_count == 0) begin
      $display("jump_event_peak_monitor_top: match");
    end else begin
      $display("jump_event_peak_monitor_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/jepm_pkg.sv
design/jepm_fifo.sv
design/jepm_front.sv
design/jepm_back.sv
design/jump_event_peak_monitor_top.sv
design/jepm_checker.sv
tb/jepm_peak_checker.sv
tb/tb_jump_event_peak_monitor_top.sv
